// File: rtl/cgst_pkg.sv
// Shared constants, types and request and response structs for the colour gradient stop table.
package cgst_pkg;

    // table geometry
    localparam int MAX_STOPS = 16;
    localparam int IDX_W     = $clog2(MAX_STOPS);
    localparam int CNT_W     = $clog2(MAX_STOPS + 1);

    // field widths
    localparam int POS_W  = 17;
    localparam int CH_W   = 8;
    localparam int COL_W  = 3 * CH_W;
    localparam int NUM_W  = CH_W + POS_W;
    localparam int STEP_W = $clog2(CH_W);

    typedef logic [POS_W-1:0] t_pos;
    typedef logic [CH_W-1:0]  t_chv;
    typedef logic [COL_W-1:0] t_color;
    typedef logic [IDX_W-1:0] t_idx;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [NUM_W-1:0] t_num;

    // position end points, fixed point with 65536 as one
    localparam t_pos POS_ZERO = '0;
    localparam t_pos POS_ONE  = t_pos'(65536);

    localparam t_color COL_BLACK = '0;
    localparam t_color COL_WHITE = '1;

    // operation and status codes
    localparam logic OP_ADD      = 1'b0;
    localparam logic OP_LOOKUP   = 1'b1;
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    // one table entry
    typedef struct packed {
        t_pos   pos;
        t_color col;
    } t_entry;

    // access to the stop store
    typedef struct packed {
        logic   we_pos;
        logic   we_col;
        t_idx   waddr;
        t_entry wdata;
        t_idx   raddr;
    } t_mem_req;

    // divider request and response
    typedef struct packed {
        logic start;
        t_num num;
        t_pos den;
    } t_div_req;

    typedef struct packed {
        logic busy;
        logic done;
        t_chv quot;
    } t_div_rsp;

endpackage

// File: rtl/cgst_if.sv
// Valid/ready channel interfaces for the request and result words.
interface cgst_in_if;
    logic              valid;
    logic              ready;
    logic              op;
    cgst_pkg::t_pos    position;
    cgst_pkg::t_chv    red_in;
    cgst_pkg::t_chv    green_in;
    cgst_pkg::t_chv    blue_in;

    modport source (output valid, op, position, red_in, green_in, blue_in, input ready);
    modport sink   (input valid, op, position, red_in, green_in, blue_in, output ready);
endinterface

interface cgst_out_if;
    logic              valid;
    logic              ready;
    cgst_pkg::t_chv    red;
    cgst_pkg::t_chv    green;
    cgst_pkg::t_chv    blue;
    logic              status;

    modport source (output valid, red, green, blue, status, input ready);
    modport sink   (input valid, red, green, blue, status, output ready);
endinterface

// File: rtl/cgst_store.sv
// Stop store: position and colour memories, one write and one registered read port.
module cgst_store (
    input  logic               i_clk,
    input  cgst_pkg::t_mem_req i_req,
    output cgst_pkg::t_entry   o_rdata
);
    import cgst_pkg::*;

    t_pos   r_pos_mem [MAX_STOPS];
    t_color r_col_mem [MAX_STOPS];
    t_entry r_rdata;

    // writes, position and colour enabled separately
    always_ff @(posedge i_clk) begin
        if (i_req.we_pos) begin
            r_pos_mem[i_req.waddr] <= i_req.wdata.pos;
        end
        if (i_req.we_col) begin
            r_col_mem[i_req.waddr] <= i_req.wdata.col;
        end
    end

    // read, registered
    always_ff @(posedge i_clk) begin
        r_rdata.pos <= r_pos_mem[i_req.raddr];
        r_rdata.col <= r_col_mem[i_req.raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/cgst_div.sv
// Restoring divider, one quotient bit per cycle, quotient known to fit one channel.
module cgst_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cgst_pkg::t_div_req i_req,
    output cgst_pkg::t_div_rsp o_rsp
);
    import cgst_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    t_num              r_rem;
    t_num              r_sh;
    t_chv              r_q;
    logic              w_bit;

    assign w_bit = (r_rem >= r_sh);

    // start loads the divisor aligned to the top quotient bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            // done pulses for one cycle after the last quotient bit
            r_done <= !i_req.start && r_busy && (r_step == '0);
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(CH_W - 1);
                r_rem  <= i_req.num;
                r_sh   <= NUM_W'(i_req.den) << (CH_W - 1);
            end else if (r_busy) begin
                if (w_bit) begin
                    r_rem <= r_rem - r_sh;
                end
                r_q  <= {r_q[CH_W-2:0], w_bit};
                r_sh <= r_sh >> 1;
                r_step <= r_step - STEP_W'(1);
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_q;

endmodule

// File: rtl/color_gradient_stop_table.sv
// Colour gradient stop table: sequencer around the stop store and the shared divider.
//
//   channel  dir  word                                      handshake
//   i_in     in   op, position, red_in, green_in, blue_in   valid/ready
//   o_out    out  red, green, blue, status                  valid/ready
//
// One word at a time. An add at an end goes straight to the result; an inner add
// walks a search and a shift through the single read port of the store, and takes
// longer as the count grows. A lookup inside the range runs the search up to the
// upper stop found, then the three channels in turn on the shared divider. After
// reset the states S_INIT0 and S_INIT1 write the end stops before the first word is
// taken. A stalled result waits in the output register while the next word is
// already in work; that word's result waits for the register.
module color_gradient_stop_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cgst_in_if.sink     i_in,
    cgst_out_if.source  o_out
);
    import cgst_pkg::*;

    typedef enum logic [3:0] {
        S_INIT0, S_INIT1, S_IDLE, S_DECIDE, S_END_WAIT,
        S_SRCH_RD, S_SRCH_CMP, S_SHIFT_RD, S_SHIFT_WR, S_INSERT,
        S_LEFT_RD, S_LEFT_WAIT, S_MIX, S_DIV_START, S_DIV_WAIT, S_OUT
    } t_state;

    typedef enum logic [1:0] {CH_R, CH_G, CH_B} t_chan;

    t_state   r_state;
    t_cnt     r_count;
    t_idx     r_k;
    t_idx     r_i;
    logic     r_op;
    t_pos     r_v;
    t_color   r_col;
    t_pos     r_p2;
    t_color   r_c1;
    t_color   r_c2;
    t_pos     r_n;
    t_pos     r_d;
    t_chan    r_ch;
    t_num     r_num;
    t_color   r_res;
    logic     r_status;
    logic     r_o_valid;
    t_color   r_out_res;
    logic     r_out_status;

    t_mem_req mem_req;
    t_entry   mem_rdata;
    t_div_req div_req;
    t_div_rsp div_rsp;

    t_idx     w_last;
    t_idx     w_k_dec;
    t_chv     w_c1;
    t_chv     w_c2;
    t_pos     w_dn;
    t_num     w_num;

    assign w_last  = IDX_W'(r_count - CNT_W'(1));
    assign w_k_dec = r_k - IDX_W'(1);

    cgst_store u_store (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    cgst_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // store access by state; no read follows a write to the same entry closely
    always_comb begin
        mem_req = '0;
        unique case (r_state)
            S_INIT0: begin
                mem_req.we_pos = 1'b1;
                mem_req.we_col = 1'b1;
                mem_req.waddr  = '0;
                mem_req.wdata  = '{pos: POS_ZERO, col: COL_BLACK};
            end
            S_INIT1: begin
                mem_req.we_pos = 1'b1;
                mem_req.we_col = 1'b1;
                mem_req.waddr  = IDX_W'(1);
                mem_req.wdata  = '{pos: POS_ONE, col: COL_WHITE};
            end
            S_DECIDE: begin
                if (r_op == OP_ADD) begin
                    mem_req.we_col    = (r_v == POS_ZERO) || (r_v == POS_ONE);
                    mem_req.waddr     = (r_v == POS_ONE) ? w_last : '0;
                    mem_req.wdata.col = r_col;
                end else begin
                    mem_req.raddr = (r_v == POS_ONE) ? w_last : '0;
                end
            end
            S_SRCH_RD:  mem_req.raddr = r_k;
            S_SHIFT_RD: mem_req.raddr = w_k_dec;
            S_SHIFT_WR: begin
                mem_req.we_pos = 1'b1;
                mem_req.we_col = 1'b1;
                mem_req.waddr  = r_k;
                mem_req.wdata  = mem_rdata;
            end
            S_INSERT: begin
                mem_req.we_pos = 1'b1;
                mem_req.we_col = 1'b1;
                mem_req.waddr  = r_i;
                mem_req.wdata  = '{pos: r_v, col: r_col};
            end
            S_LEFT_RD:  mem_req.raddr = r_i - IDX_W'(1);
            default: ;
        endcase
    end

    // channel select and weighted sum for the current channel
    always_comb begin
        unique case (r_ch)
            CH_R: begin
                w_c1 = r_c1[COL_W-1 -: CH_W];
                w_c2 = r_c2[COL_W-1 -: CH_W];
            end
            CH_G: begin
                w_c1 = r_c1[2*CH_W-1 -: CH_W];
                w_c2 = r_c2[2*CH_W-1 -: CH_W];
            end
            default: begin
                w_c1 = r_c1[CH_W-1:0];
                w_c2 = r_c2[CH_W-1:0];
            end
        endcase
    end

    assign w_dn  = r_d - r_n;
    assign w_num = NUM_W'(w_c1) * NUM_W'(w_dn) + NUM_W'(w_c2) * NUM_W'(r_n);

    assign div_req.start = (r_state == S_DIV_START);
    assign div_req.num   = r_num;
    assign div_req.den   = r_d;

    // sequencer with registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT0;
            r_count   <= CNT_W'(2);
            r_o_valid <= 1'b0;
        end else begin
            // output register empties on a taken word unless refilled below
            if (r_o_valid && o_out.ready && (r_state != S_OUT)) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_INIT0: r_state <= S_INIT1;
                S_INIT1: r_state <= S_IDLE;
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_op     <= i_in.op;
                        r_v      <= (i_in.position > POS_ONE) ? POS_ONE : i_in.position;
                        r_col    <= {i_in.red_in, i_in.green_in, i_in.blue_in};
                        r_res    <= '0;
                        r_status <= STATUS_OK;
                        r_state  <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    if (r_op == OP_ADD) begin
                        if ((r_v == POS_ZERO) || (r_v == POS_ONE)) begin
                            r_state <= S_OUT;
                        end else if (r_count >= CNT_W'(MAX_STOPS)) begin
                            r_status <= STATUS_FULL;
                            r_state  <= S_OUT;
                        end else begin
                            r_k     <= IDX_W'(1);
                            r_state <= S_SRCH_RD;
                        end
                    end else if ((r_v == POS_ZERO) || (r_v == POS_ONE)) begin
                        r_state <= S_END_WAIT;
                    end else begin
                        r_k     <= IDX_W'(1);
                        r_state <= S_SRCH_RD;
                    end
                end
                S_END_WAIT: begin
                    r_res   <= mem_rdata.col;
                    r_state <= S_OUT;
                end
                S_SRCH_RD: r_state <= S_SRCH_CMP;
                // first stop at or above the position; the last stop always ends it
                S_SRCH_CMP: begin
                    if (mem_rdata.pos >= r_v) begin
                        r_i  <= r_k;
                        r_p2 <= mem_rdata.pos;
                        r_c2 <= mem_rdata.col;
                        if (r_op == OP_ADD) begin
                            r_k     <= r_count[IDX_W-1:0];
                            r_state <= S_SHIFT_RD;
                        end else begin
                            r_state <= S_LEFT_RD;
                        end
                    end else begin
                        r_k     <= r_k + IDX_W'(1);
                        r_state <= S_SRCH_RD;
                    end
                end
                S_SHIFT_RD: r_state <= S_SHIFT_WR;
                // move one entry up, top down, until the gap reaches the slot
                S_SHIFT_WR: begin
                    r_k     <= w_k_dec;
                    r_state <= (w_k_dec == r_i) ? S_INSERT : S_SHIFT_RD;
                end
                S_INSERT: begin
                    r_count <= r_count + CNT_W'(1);
                    r_state <= S_OUT;
                end
                S_LEFT_RD: r_state <= S_LEFT_WAIT;
                S_LEFT_WAIT: begin
                    r_c1    <= mem_rdata.col;
                    r_n     <= r_v - mem_rdata.pos;
                    r_d     <= r_p2 - mem_rdata.pos;
                    r_ch    <= CH_R;
                    r_state <= S_MIX;
                end
                S_MIX: begin
                    r_num   <= w_num;
                    r_state <= S_DIV_START;
                end
                S_DIV_START: r_state <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (div_rsp.done) begin
                        unique case (r_ch)
                            CH_R: begin
                                r_res[COL_W-1 -: CH_W] <= div_rsp.quot;
                                r_ch    <= CH_G;
                                r_state <= S_MIX;
                            end
                            CH_G: begin
                                r_res[2*CH_W-1 -: CH_W] <= div_rsp.quot;
                                r_ch    <= CH_B;
                                r_state <= S_MIX;
                            end
                            default: begin
                                r_res[CH_W-1:0] <= div_rsp.quot;
                                r_state <= S_OUT;
                            end
                        endcase
                    end
                end
                S_OUT: begin
                    if (!r_o_valid || o_out.ready) begin
                        r_o_valid    <= 1'b1;
                        r_out_res    <= r_res;
                        r_out_status <= r_status;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready   = (r_state == S_IDLE);
    assign o_out.valid  = r_o_valid;
    assign o_out.red    = r_out_res[COL_W-1 -: CH_W];
    assign o_out.green  = r_out_res[2*CH_W-1 -: CH_W];
    assign o_out.blue   = r_out_res[CH_W-1:0];
    assign o_out.status = r_out_status;

`ifndef NO_ASSERTIONS
    // stop count stays within the table
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) && (r_count <= CNT_W'(MAX_STOPS)))
        else $error("stop count out of range");

    // only an insert changes the stop count
    a_count_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_INSERT) |=> (r_count == $past(r_count)))
        else $error("stop count changed outside insert");

    // the search never walks past the last stop
    a_search_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SRCH_RD) |-> (r_k <= w_last))
        else $error("search beyond last stop");

    // the divider is never restarted mid-division
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");
`endif

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// Testbench for the colour gradient stop table: directed table, random words, scoreboard.
module tb;
    import cgst_pkg::*;

    // one result word
    typedef struct packed {
        t_chv red;
        t_chv green;
        t_chv blue;
        logic status;
    } t_result;

    // one request word, with an optional typed-in expectation
    typedef struct packed {
        logic    op;
        t_pos    pos;
        t_chv    r;
        t_chv    g;
        t_chv    b;
        logic    chk;
        t_result exp;
    } t_stim;

    localparam int N_DIR     = 27;
    localparam int LONG_HOLD = 400;
    localparam int SEG_WORDS = 50;
    localparam int N_SEG     = 20;

    // directed part: reset state, end points, saturation, inserts, duplicate, full table
    localparam t_stim DIR_TBL [N_DIR] = '{
        '{OP_LOOKUP, 17'd0,      8'h00, 8'h00, 8'h00, 1'b1, '{8'h00, 8'h00, 8'h00, STATUS_OK}},
        '{OP_LOOKUP, 17'd131071, 8'hff, 8'hff, 8'hff, 1'b1, '{8'hff, 8'hff, 8'hff, STATUS_OK}},
        '{OP_LOOKUP, 17'd32768,  8'h00, 8'h00, 8'h00, 1'b1, '{8'h7f, 8'h7f, 8'h7f, STATUS_OK}},
        '{OP_ADD,    17'd0,      8'h12, 8'h34, 8'h56, 1'b1, '{8'h00, 8'h00, 8'h00, STATUS_OK}},
        '{OP_ADD,    17'd70000,  8'hff, 8'h00, 8'h80, 1'b1, '{8'h00, 8'h00, 8'h00, STATUS_OK}},
        '{OP_LOOKUP, 17'd0,      8'h00, 8'h00, 8'h00, 1'b1, '{8'h12, 8'h34, 8'h56, STATUS_OK}},
        '{OP_LOOKUP, 17'd65536,  8'h00, 8'h00, 8'h00, 1'b1, '{8'hff, 8'h00, 8'h80, STATUS_OK}},
        '{OP_ADD,    17'd1,      8'hff, 8'hff, 8'hff, 1'b1, '{8'h00, 8'h00, 8'h00, STATUS_OK}},
        '{OP_ADD,    17'd65535,  8'h00, 8'h00, 8'h00, 1'b1, '{8'h00, 8'h00, 8'h00, STATUS_OK}},
        '{OP_ADD,    17'd32768,  8'haa, 8'h55, 8'h0f, 1'b1, '{8'h00, 8'h00, 8'h00, STATUS_OK}},
        '{OP_ADD,    17'd32768,  8'h01, 8'h02, 8'h03, 1'b1, '{8'h00, 8'h00, 8'h00, STATUS_OK}},
        '{OP_LOOKUP, 17'd1,      8'hff, 8'hff, 8'hff, 1'b0, '0},
        '{OP_LOOKUP, 17'd32768,  8'h00, 8'h00, 8'h00, 1'b0, '0},
        '{OP_LOOKUP, 17'd49152,  8'h5a, 8'ha5, 8'h3c, 1'b0, '0},
        '{OP_ADD,    17'd16384,  8'hff, 8'h00, 8'hff, 1'b0, '0},
        '{OP_ADD,    17'd8192,   8'h00, 8'hff, 8'h00, 1'b0, '0},
        '{OP_ADD,    17'd24576,  8'h80, 8'h40, 8'h20, 1'b0, '0},
        '{OP_ADD,    17'd1,      8'h10, 8'h20, 8'h30, 1'b0, '0},
        '{OP_ADD,    17'd40000,  8'hfe, 8'h01, 8'h7f, 1'b0, '0},
        '{OP_ADD,    17'd57344,  8'h33, 8'hcc, 8'h99, 1'b0, '0},
        '{OP_ADD,    17'd65534,  8'hff, 8'hff, 8'h00, 1'b0, '0},
        '{OP_ADD,    17'd2,      8'h00, 8'h00, 8'hff, 1'b0, '0},
        '{OP_ADD,    17'd60000,  8'h77, 8'h88, 8'h99, 1'b0, '0},
        '{OP_ADD,    17'd12345,  8'hc3, 8'h3c, 8'h81, 1'b0, '0},
        '{OP_ADD,    17'd20000,  8'hff, 8'hff, 8'hff, 1'b1, '{8'h00, 8'h00, 8'h00, STATUS_FULL}},
        '{OP_ADD,    17'd0,      8'h00, 8'h00, 8'h00, 1'b1, '{8'h00, 8'h00, 8'h00, STATUS_OK}},
        '{OP_LOOKUP, 17'd65534,  8'h00, 8'h00, 8'h00, 1'b0, '0}
    };

    logic i_clk;
    logic i_rst_n;

    cgst_in_if  req_if ();
    cgst_out_if res_if ();

    color_gradient_stop_table i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if)
    );

    // gradient state as seen by the scoreboard
    t_pos        grad_pos [MAX_STOPS];
    t_color      grad_col [MAX_STOPS];
    int unsigned grad_cnt;

    t_result     colour_q [$];
    int          fail_cnt;

    // typed-in expectation travelling with the word on offer
    logic        cur_chk;
    t_result     cur_exp;

    int          tx_idle_pct;
    int          rx_idle_pct;
    bit          hold_long;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

    // upper stop of the bracket around v, kept inside 1..count-1
    function automatic int unsigned upper_stop(t_pos v);
        int unsigned i;
        for (i = 0; i < grad_cnt; i++) begin
            if (grad_pos[i] >= v)
                break;
        end
        if (i > grad_cnt - 1)
            i = grad_cnt - 1;
        if (i == 0)
            i = 1;
        return i;
    endfunction

    // one channel of the linear mix, rounded down
    function automatic t_chv blend(t_chv c1, t_chv c2, t_pos n, t_pos d);
        longint unsigned acc;
        if (d == '0)
            return c1;
        acc = longint'(c1) * longint'(d - n) + longint'(c2) * longint'(n);
        return t_chv'(acc / d);
    endfunction

    // update the gradient with one word and work out its result
    task automatic gradient_step(input logic op, input t_pos raw, input t_chv r, input t_chv g,
                                 input t_chv b, output t_result res);
        t_pos        v;
        t_pos        p1;
        t_pos        p2;
        t_color      c;
        t_color      c1;
        t_color      c2;
        int unsigned last;
        int unsigned hi;
        int unsigned k;
        v    = (raw > POS_ONE) ? POS_ONE : raw;
        last = grad_cnt - 1;
        res  = '0;
        if (op == OP_ADD) begin
            if (v == POS_ZERO) begin
                grad_col[0] = {r, g, b};
            end else if (v == POS_ONE) begin
                grad_col[last] = {r, g, b};
            end else if (grad_cnt >= MAX_STOPS) begin
                res.status = STATUS_FULL;
            end else begin
                hi = upper_stop(v);
                for (k = grad_cnt; k > hi; k--) begin
                    grad_pos[k] = grad_pos[k-1];
                    grad_col[k] = grad_col[k-1];
                end
                grad_pos[hi] = v;
                grad_col[hi] = {r, g, b};
                grad_cnt++;
            end
        end else begin
            if (v == POS_ZERO) begin
                c = grad_col[0];
            end else if (v == POS_ONE) begin
                c = grad_col[last];
            end else begin
                hi = upper_stop(v);
                p1 = grad_pos[hi-1];
                p2 = grad_pos[hi];
                c1 = grad_col[hi-1];
                c2 = grad_col[hi];
                if (p2 <= p1 || v < p1 || v > p2) begin
                    c = c1;
                end else begin
                    c = {blend(c1[23:16], c2[23:16], v - p1, p2 - p1),
                         blend(c1[15:8],  c2[15:8],  v - p1, p2 - p1),
                         blend(c1[7:0],   c2[7:0],   v - p1, p2 - p1)};
                end
            end
            res.red    = c[23:16];
            res.green  = c[15:8];
            res.blue   = c[7:0];
            res.status = STATUS_OK;
        end
    endtask

    // channel value, extremes now and then
    function automatic t_chv rand_chan();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hff;
            default: return t_chv'($urandom);
        endcase
    endfunction

    // random word: mostly lookups, adds biased to the ends since the table is full by now
    function automatic t_stim rand_word();
        t_stim       w;
        int unsigned sel;
        t_pos        near;
        w     = '0;
        w.r   = rand_chan();
        w.g   = rand_chan();
        w.b   = rand_chan();
        w.op  = ($urandom_range(0, 99) < 30) ? OP_ADD : OP_LOOKUP;
        sel   = $urandom_range(0, 19);
        near  = grad_pos[$urandom_range(0, grad_cnt - 1)];
        if (w.op == OP_ADD) begin
            if (sel < 8)
                w.pos = POS_ZERO;
            else if (sel < 14)
                w.pos = POS_ONE;
            else if (sel < 16)
                w.pos = t_pos'($urandom_range(65537, 131071));
            else
                w.pos = t_pos'($urandom_range(1, 65535));
        end else begin
            case (sel)
                0:          w.pos = POS_ZERO;
                1:          w.pos = POS_ONE;
                2:          w.pos = t_pos'($urandom_range(65537, 131071));
                3, 4, 5, 6: w.pos = near;
                7:          w.pos = near + 1'b1;
                8:          w.pos = near - 1'b1;
                default:    w.pos = t_pos'($urandom_range(1, 65535));
            endcase
        end
        return w;
    endfunction

    // offer one word, with a random gap ahead of it, and wait for it to be taken
    task automatic send_word(input t_stim w);
        if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        req_if.valid    <= 1'b1;
        req_if.op       <= w.op;
        req_if.position <= w.pos;
        req_if.red_in   <= w.r;
        req_if.green_in <= w.g;
        req_if.blue_in  <= w.b;
        cur_chk         <= w.chk;
        cur_exp         <= w.exp;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    // hold the sender until every outstanding result is back
    task automatic pause_until_empty();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (colour_q.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic int pick_idle();
        case ($urandom_range(0, 2))
            0: return 0;
            1: return 10;
            default: return 40;
        endcase
    endfunction

    // result side: random stall bursts, and one long hold-off on request
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_long) begin
                res_if.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                hold_long = 1'b0;
                res_if.ready <= 1'b1;
            end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
                res_if.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                res_if.ready <= 1'b1;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // scoreboard: predict on each taken request word, check each taken result word
    always @(posedge i_clk) begin
        t_result pred;
        t_result want;
        if (i_rst_n) begin
            if (req_if.valid && req_if.ready) begin
                gradient_step(req_if.op, req_if.position, req_if.red_in, req_if.green_in,
                              req_if.blue_in, pred);
                colour_q.push_back(cur_chk ? cur_exp : pred);
            end
            if (res_if.valid && res_if.ready) begin
                if (colour_q.size() == 0) begin
                    $error("result word with none expected");
                    fail_cnt++;
                end else begin
                    want = colour_q.pop_front();
                    if (res_if.red !== want.red) begin
                        $error("red: expected %0d, got %0d", want.red, res_if.red);
                        fail_cnt++;
                    end
                    if (res_if.green !== want.green) begin
                        $error("green: expected %0d, got %0d", want.green, res_if.green);
                        fail_cnt++;
                    end
                    if (res_if.blue !== want.blue) begin
                        $error("blue: expected %0d, got %0d", want.blue, res_if.blue);
                        fail_cnt++;
                    end
                    if (res_if.status !== want.status) begin
                        $error("status: expected %0d, got %0d", want.status, res_if.status);
                        fail_cnt++;
                    end
                end
            end
        end
    end

    // main sequence
    initial begin
        int i;
        int seg;
        int guard;
        i_rst_n         = 1'b0;
        req_if.valid    = 1'b0;
        req_if.op       = OP_LOOKUP;
        req_if.position = '0;
        req_if.red_in   = '0;
        req_if.green_in = '0;
        req_if.blue_in  = '0;
        cur_chk         = 1'b0;
        cur_exp         = '0;
        fail_cnt        = 0;
        tx_idle_pct     = 0;
        rx_idle_pct     = 0;
        hold_long       = 1'b0;
        for (i = 0; i < MAX_STOPS; i++) begin
            grad_pos[i] = '0;
            grad_col[i] = '0;
        end
        grad_pos[1] = POS_ONE;
        grad_col[1] = COL_WHITE;
        grad_cnt    = 2;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table
        tx_idle_pct = 10;
        rx_idle_pct = 10;
        for (i = 0; i < N_DIR; i++)
            send_word(DIR_TBL[i]);
        pause_until_empty();

        // random segments, quiet at the end
        for (seg = 0; seg < N_SEG; seg++) begin
            if (seg >= N_SEG - 2) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else begin
                tx_idle_pct = pick_idle();
                rx_idle_pct = pick_idle();
            end
            // back up the block behind a stalled receiver
            if (seg == 5) begin
                tx_idle_pct = 0;
                hold_long   = 1'b1;
            end
            if (seg == 9 || seg == 14)
                pause_until_empty();
            repeat (SEG_WORDS) send_word(rand_word());
        end
        req_if.valid <= 1'b0;

        // drain, then let the pipe settle
        guard = 0;
        while (colour_q.size() != 0 && guard < 5000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (200) @(posedge i_clk);
        if (colour_q.size() != 0) begin
            $error("%0d result words never arrived", colour_q.size());
            fail_cnt++;
        end

        if (fail_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
